FILE: rtl/core/bfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrc_pkg
// Shared types, codes and the byte-wide crc update for the fragment
// reassembly checker.
// ----------------------------------------------------------------------------
package bfrc_pkg;

    // packet type bytes
    localparam logic [7:0] PKT_FIRST  = 8'h00;
    localparam logic [7:0] PKT_MIDDLE = 8'h40;
    localparam logic [7:0] PKT_SINGLE = 8'h80;
    localparam logic [7:0] PKT_FINAL  = 8'hC0;

    // frame check constants
    localparam logic [7:0]  MAGIC_BYTE = 8'h3A;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [16:0] LEN_MAX    = 17'h1FFFF;
    localparam logic [16:0] LEN_MIN    = 17'd3;

    // result status codes
    localparam logic [2:0] STATUS_NONE      = 3'd0;
    localparam logic [2:0] STATUS_OK        = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [2:0] STATUS_BAD_SIZE  = 3'd3;
    localparam logic [2:0] STATUS_BAD_CRC   = 3'd4;
    localparam logic [2:0] STATUS_UNKNOWN   = 3'd5;

    // packet parser mode
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_LAST   = 3'd2,
        MODE_LONE   = 3'd3,
        MODE_DROP   = 3'd4
    } mode_t;

    // crc-16/ccitt-false update over one byte, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/ble_fragment_reassembly_checker_core.sv
`timescale 1ns / 1ps
// A transaction accepted into the input register passes through the frame logic into the result register.
// Throughput: one byte per cycle; the input register and the result register each
// take a new transaction whenever the stage after them moves on.
// The crc update, length counter and frame check are combinational logic between those registers.
// Reset (rst_n low, asynchronous): parser between packets, both frames empty with crc 0xFFFF,
// crc check enabled, no transaction held in either register.
// ----------------------------------------------------------------------------
// ble_fragment_reassembly_checker_core
// Byte-serial packet parser that reassembles multi-packet and lone frames,
// echoes frame bytes with offsets and checks magic, size and crc at frame end.
// ----------------------------------------------------------------------------
module ble_fragment_reassembly_checker_core
    import bfrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_enable,
    input  logic        cfg_write_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  packet_byte,
    input  logic        packet_start,
    input  logic        packet_end,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        byte_in_frame,
    output logic [15:0] frame_offset,
    output logic        frame_is_lone,
    output logic        frame_end,
    output logic [2:0]  status
);

    // configuration register
    logic crc_en_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       end_reg;

    // frame state
    mode_t       mode_reg, mode_next;
    logic [15:0] m_crc_reg, m_crc_next;
    logic [16:0] m_len_reg, m_len_next;
    logic [15:0] m_size_reg, m_size_next;
    logic [7:0]  m_magic_reg, m_magic_next;
    logic [15:0] l_crc_reg, l_crc_next;
    logic [16:0] l_len_reg, l_len_next;
    logic [15:0] l_size_reg, l_size_next;
    logic [7:0]  l_magic_reg, l_magic_next;

    // result stage
    logic        out_valid_reg;
    logic [7:0]  res_byte_reg;
    logic        res_in_frame_reg, res_in_frame_next;
    logic [15:0] res_offset_reg, res_offset_next;
    logic        res_lone_reg, res_lone_next;
    logic        res_end_reg, res_end_next;
    logic [2:0]  res_status_reg, res_status_next;

    // combinational helpers
    logic        advance;
    logic        add_multi;
    logic        add_lone;
    logic [16:0] add_off;
    logic [15:0] add_crc;
    logic [16:0] add_len;
    logic [15:0] add_size;
    logic [7:0]  add_magic;
    logic [15:0] chk_crc;
    logic [16:0] chk_len;
    logic [15:0] chk_size;
    logic [7:0]  chk_magic;
    logic [2:0]  chk_status;

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
        end
        else if (cfg_write_enable)
        begin
            crc_en_reg <= cfg_write_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= packet_byte;
            start_reg <= packet_start;
            end_reg   <= packet_end;
        end
    end

    // selection of the frame that takes a data byte
    assign add_multi = !start_reg && (mode_reg == MODE_APPEND || mode_reg == MODE_LAST);
    assign add_lone  = !start_reg && (mode_reg == MODE_LONE);

    // byte append: offset capture, crc update, saturating length
    always_comb
    begin
        logic [15:0] src_crc;
        logic [16:0] src_len;
        logic [15:0] src_size;
        logic [7:0]  src_magic;
        src_crc   = add_lone ? l_crc_reg   : m_crc_reg;
        src_len   = add_lone ? l_len_reg   : m_len_reg;
        src_size  = add_lone ? l_size_reg  : m_size_reg;
        src_magic = add_lone ? l_magic_reg : m_magic_reg;
        add_off   = src_len;
        add_size  = src_size;
        add_magic = src_magic;
        if (src_len == 17'd0)
        begin
            add_size = {src_size[15:8], byte_reg};
        end
        else if (src_len == 17'd1)
        begin
            add_size = {byte_reg, src_size[7:0]};
        end
        else if (src_len == 17'd2)
        begin
            add_magic = byte_reg;
        end
        add_crc = crc16_byte(src_crc, byte_reg);
        add_len = (src_len < LEN_MAX) ? src_len + 17'd1 : src_len;
    end

    // parser: type decode, frame update, end-of-packet check
    always_comb
    begin
        mode_next         = mode_reg;
        m_crc_next        = m_crc_reg;
        m_len_next        = m_len_reg;
        m_size_next       = m_size_reg;
        m_magic_next      = m_magic_reg;
        l_crc_next        = l_crc_reg;
        l_len_next        = l_len_reg;
        l_size_next       = l_size_reg;
        l_magic_next      = l_magic_reg;
        res_in_frame_next = 1'b0;
        res_offset_next   = 16'd0;
        res_lone_next     = 1'b0;
        res_end_next      = 1'b0;
        res_status_next   = STATUS_NONE;

        if (start_reg)
        begin
            case (byte_reg)
                PKT_FIRST:
                begin
                    m_crc_next   = CRC_INIT;
                    m_len_next   = 17'd0;
                    m_size_next  = 16'd0;
                    m_magic_next = 8'd0;
                    mode_next    = MODE_APPEND;
                end
                PKT_MIDDLE:
                begin
                    mode_next = MODE_APPEND;
                end
                PKT_FINAL:
                begin
                    mode_next = MODE_LAST;
                end
                PKT_SINGLE:
                begin
                    l_crc_next   = CRC_INIT;
                    l_len_next   = 17'd0;
                    l_size_next  = 16'd0;
                    l_magic_next = 8'd0;
                    mode_next    = MODE_LONE;
                end
                default:
                begin
                    res_status_next = STATUS_UNKNOWN;
                    mode_next       = MODE_DROP;
                end
            endcase
        end
        else if (add_multi)
        begin
            res_in_frame_next = 1'b1;
            res_offset_next   = add_off[16] ? 16'hFFFF : add_off[15:0];
            m_crc_next        = add_crc;
            m_len_next        = add_len;
            m_size_next       = add_size;
            m_magic_next      = add_magic;
        end
        else if (add_lone)
        begin
            res_in_frame_next = 1'b1;
            res_lone_next     = 1'b1;
            res_offset_next   = add_off[16] ? 16'hFFFF : add_off[15:0];
            l_crc_next        = add_crc;
            l_len_next        = add_len;
            l_size_next       = add_size;
            l_magic_next      = add_magic;
        end

        // frame check on the updated frame state
        chk_crc   = (mode_next == MODE_LONE) ? l_crc_next   : m_crc_next;
        chk_len   = (mode_next == MODE_LONE) ? l_len_next   : m_len_next;
        chk_size  = (mode_next == MODE_LONE) ? l_size_next  : m_size_next;
        chk_magic = (mode_next == MODE_LONE) ? l_magic_next : m_magic_next;
        if (chk_len < LEN_MIN || chk_magic != MAGIC_BYTE)
        begin
            chk_status = STATUS_BAD_MAGIC;
        end
        else if ({1'b0, chk_size} != chk_len)
        begin
            chk_status = STATUS_BAD_SIZE;
        end
        else if (crc_en_reg && chk_crc != 16'd0)
        begin
            chk_status = STATUS_BAD_CRC;
        end
        else
        begin
            chk_status = STATUS_OK;
        end

        // end of packet
        if (end_reg && mode_next != MODE_IDLE)
        begin
            if (mode_next == MODE_LAST)
            begin
                res_end_next    = 1'b1;
                res_status_next = chk_status;
                m_crc_next      = CRC_INIT;
                m_len_next      = 17'd0;
                m_size_next     = 16'd0;
                m_magic_next    = 8'd0;
            end
            else if (mode_next == MODE_LONE)
            begin
                res_end_next    = 1'b1;
                res_lone_next   = 1'b1;
                res_status_next = chk_status;
            end
            mode_next = MODE_IDLE;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            m_crc_reg   <= CRC_INIT;
            m_len_reg   <= 17'd0;
            m_size_reg  <= 16'd0;
            m_magic_reg <= 8'd0;
            l_crc_reg   <= CRC_INIT;
            l_len_reg   <= 17'd0;
            l_size_reg  <= 16'd0;
            l_magic_reg <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            m_crc_reg   <= m_crc_next;
            m_len_reg   <= m_len_next;
            m_size_reg  <= m_size_next;
            m_magic_reg <= m_magic_next;
            l_crc_reg   <= l_crc_next;
            l_len_reg   <= l_len_next;
            l_size_reg  <= l_size_next;
            l_magic_reg <= l_magic_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_byte_reg     <= byte_reg;
            res_in_frame_reg <= res_in_frame_next;
            res_offset_reg   <= res_offset_next;
            res_lone_reg     <= res_lone_next;
            res_end_reg      <= res_end_next;
            res_status_reg   <= res_status_next;
        end
    end

    // output drive
    assign out_valid     = out_valid_reg;
    assign frame_byte    = res_byte_reg;
    assign byte_in_frame = res_in_frame_reg;
    assign frame_offset  = res_offset_reg;
    assign frame_is_lone = res_lone_reg;
    assign frame_end     = res_end_reg;
    assign status        = res_status_reg;

endmodule

FILE: rtl/core/bfrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrc_checker
// Port-level assertions for the fragment reassembly checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module bfrc_checker
    import bfrc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  frame_byte,
    input logic        byte_in_frame,
    input logic [15:0] frame_offset,
    input logic        frame_is_lone,
    input logic        frame_end,
    input logic [2:0]  status
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
            && $stable(frame_offset) && $stable(status) && $stable(frame_end))
    else $error("stalled result transaction changed");

    // check codes appear exactly on frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_end == (status == STATUS_OK || status == STATUS_BAD_MAGIC
            || status == STATUS_BAD_SIZE || status == STATUS_BAD_CRC))
    else $error("frame end and check status disagree");

    // bytes outside a frame carry no offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_in_frame |-> frame_offset == 16'd0)
    else $error("offset on a byte outside a frame");

    // unknown type is reported on the type byte only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_UNKNOWN |-> !byte_in_frame && !frame_is_lone)
    else $error("unknown type reported on a frame byte");

endmodule

bind ble_fragment_reassembly_checker_core bfrc_checker u_bfrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_in_frame (byte_in_frame),
    .frame_offset  (frame_offset),
    .frame_is_lone (frame_is_lone),
    .frame_end     (frame_end),
    .status        (status)
);
